[rtl/ps2kb_pkg.sv]
// Package for the PS/2 set-1 scancode decoder with character ring.
// Holds item types, ring sizing, scancode constants and the key map.
// No dependencies.
package ps2kb_pkg;

  localparam int RingSlots = 10;
  localparam int PtrW      = $clog2(RingSlots);

  typedef logic [PtrW-1:0] ptr_t;

  localparam logic OpScan = 1'b0;
  localparam logic OpRead = 1'b1;

  localparam logic [7:0] ScShiftLMake  = 8'h2a;
  localparam logic [7:0] ScShiftRMake  = 8'h36;
  localparam logic [7:0] ScShiftLBreak = 8'haa;
  localparam logic [7:0] ScShiftRBreak = 8'hb6;
  localparam logic [7:0] ScCapsMake    = 8'h3a;
  localparam logic [7:0] ScCapsBreak   = 8'hba;
  localparam logic [7:0] ScAltMake     = 8'h38;
  localparam logic [7:0] ScAltBreak    = 8'hb8;
  localparam logic [7:0] ScCtrlMake    = 8'h1d;
  localparam logic [7:0] ScCtrlBreak   = 8'h9d;
  localparam logic [7:0] ScLastMapped  = 8'h39;
  localparam logic [7:0] AsciiLowerC   = 8'h63;

  localparam int ModShift = 0;
  localparam int ModCaps  = 1;
  localparam int ModAlt   = 2;
  localparam int ModCtrl  = 3;

  typedef struct packed {
    logic       opcode;
    logic [7:0] scan_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] read_char;
    logic       read_valid;
    logic       terminate_request;
    logic       wake_readers;
    logic [3:0] modifier_flags;
  } out_t;

  function automatic ptr_t ring_next(ptr_t p);
    ptr_t n;
    n = (p == PtrW'(RingSlots - 1)) ? '0 : p + 1'b1;
    return n;
  endfunction

  // Returns {shifted, plain} character for a code up to ScLastMapped.
  function automatic logic [15:0] key_map(logic [7:0] code);
    logic [15:0] m;
    case (code)
      8'h02: m = 16'h2131;
      8'h03: m = 16'h4032;
      8'h04: m = 16'h2333;
      8'h05: m = 16'h2434;
      8'h06: m = 16'h2535;
      8'h07: m = 16'h5e36;
      8'h08: m = 16'h2637;
      8'h09: m = 16'h2a38;
      8'h0a: m = 16'h2839;
      8'h0b: m = 16'h2930;
      8'h0c: m = 16'h5f2d;
      8'h0d: m = 16'h2b3d;
      8'h0e: m = 16'h0808;
      8'h0f: m = 16'h0909;
      8'h10: m = 16'h5171;
      8'h11: m = 16'h5777;
      8'h12: m = 16'h4565;
      8'h13: m = 16'h5272;
      8'h14: m = 16'h5474;
      8'h15: m = 16'h5979;
      8'h16: m = 16'h5575;
      8'h17: m = 16'h4969;
      8'h18: m = 16'h4f6f;
      8'h19: m = 16'h5070;
      8'h1a: m = 16'h7b5b;
      8'h1b: m = 16'h7d5d;
      8'h1c: m = 16'h0a0a;
      8'h1e: m = 16'h4161;
      8'h1f: m = 16'h5373;
      8'h20: m = 16'h4464;
      8'h21: m = 16'h4666;
      8'h22: m = 16'h4767;
      8'h23: m = 16'h4868;
      8'h24: m = 16'h4a6a;
      8'h25: m = 16'h4b6b;
      8'h26: m = 16'h4c6c;
      8'h27: m = 16'h3a3b;
      8'h28: m = 16'h2227;
      8'h29: m = 16'h7e60;
      8'h2b: m = 16'h7c5c;
      8'h2c: m = 16'h5a7a;
      8'h2d: m = 16'h5878;
      8'h2e: m = 16'h4363;
      8'h2f: m = 16'h5676;
      8'h30: m = 16'h4262;
      8'h31: m = 16'h4e6e;
      8'h32: m = 16'h4d6d;
      8'h33: m = 16'h3c2c;
      8'h34: m = 16'h3e2e;
      8'h35: m = 16'h3f2f;
      default: m = 16'h2020;
    endcase
    return m;
  endfunction

endpackage

[rtl/ps2kb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ps2kb_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/ps2_scancode_to_ascii_fifo.sv]
// Top level: set-1 scancode decoder feeding a character ring held in RAM.
// Depends on ps2kb_pkg and ps2kb_ram.
// The done_o strobe comes in the cycle after accept, for both opcodes.
// Throughput: one item per cycle; busy stays low, the ring read port is
// addressed by the read pointer so read data is ready in the strobe cycle.
// Reset clears pointers, held modifier flags and the strobe; the ring RAM
// is not cleared, entries are read only after written. No stall on output.
module ps2_scancode_to_ascii_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  ps2kb_pkg::in_t   item_i,
  output logic             done_o,
  output ps2kb_pkg::out_t  result_o
);
  import ps2kb_pkg::*;

  ptr_t       wr_ptr_q, wr_ptr_d;
  ptr_t       rd_ptr_q, rd_ptr_d;
  logic [3:0] mod_q, mod_d;
  logic       done_q;
  logic       rvalid_q, term_q, wake_q;

  logic        accept;
  logic        empty;
  logic        push;
  logic        pop;
  logic        term;
  logic [15:0] pair;
  logic [7:0]  push_char;
  logic [7:0]  ram_rdata;

  assign busy   = 1'b0;
  assign accept = start & ~busy;
  assign empty  = (wr_ptr_q == rd_ptr_q);
  assign pair   = key_map(item_i.scan_byte);
  assign push_char = (mod_q[ModShift] | mod_q[ModCaps]) ? pair[15:8] : pair[7:0];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    mod_d    = mod_q;
    push     = 1'b0;
    pop      = 1'b0;
    term     = 1'b0;
    if (accept) begin
      if (item_i.opcode == OpRead) begin
        if (!empty) begin
          pop      = 1'b1;
          rd_ptr_d = ring_next(rd_ptr_q);
        end
      end else begin
        case (item_i.scan_byte)
          ScShiftLMake, ScShiftRMake:   mod_d[ModShift] = 1'b1;
          ScShiftLBreak, ScShiftRBreak: mod_d[ModShift] = 1'b0;
          ScCapsMake:                   mod_d[ModCaps]  = 1'b1;
          ScCapsBreak:                  mod_d[ModCaps]  = 1'b0;
          ScAltMake:                    mod_d[ModAlt]   = 1'b1;
          ScAltBreak:                   mod_d[ModAlt]   = 1'b0;
          ScCtrlMake:                   mod_d[ModCtrl]  = 1'b1;
          ScCtrlBreak:                  mod_d[ModCtrl]  = 1'b0;
          default: begin
            if (item_i.scan_byte <= ScLastMapped) begin
              if (mod_q[ModCtrl] && pair[7:0] == AsciiLowerC) begin
                term = 1'b1;
              end else begin
                push     = 1'b1;
                wr_ptr_d = ring_next(wr_ptr_q);
                if (ring_next(wr_ptr_q) == rd_ptr_q) begin
                  rd_ptr_d = ring_next(rd_ptr_q);
                end
              end
            end
          end
        endcase
      end
    end
  end

  ps2kb_ram #(
    .Width(8),
    .Depth(RingSlots)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (push),
    .waddr_i (wr_ptr_q),
    .wdata_i (push_char),
    .raddr_i (rd_ptr_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      mod_q    <= '0;
      done_q   <= 1'b0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      mod_q    <= mod_d;
      done_q   <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    rvalid_q <= pop;
    term_q   <= term;
    wake_q   <= accept & (item_i.opcode == OpScan);
  end

  assign done_o                     = done_q;
  assign result_o.read_char         = rvalid_q ? ram_rdata : 8'h00;
  assign result_o.read_valid        = rvalid_q;
  assign result_o.terminate_request = term_q;
  assign result_o.wake_readers      = wake_q;
  assign result_o.modifier_flags    = mod_q;

  a_done_follows_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o)
    else $error("accepted item gave no strobe");

  a_no_spurious_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> !done_o)
    else $error("strobe without accepted item");

  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_ptr_q <= PtrW'(RingSlots - 1)) && (rd_ptr_q <= PtrW'(RingSlots - 1)))
    else $error("ring pointer out of range");

  a_push_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> (wr_ptr_q != rd_ptr_q))
    else $error("ring empty after push");

  a_read_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(result_o.read_valid && (result_o.terminate_request ||
                                         result_o.wake_readers)))
    else $error("read result mixed with scancode flags");

endmodule
